>>> hw/rtl/uwxce_pkg.sv
// Package: shared types, opcodes and constants of the chunk emitter.
`timescale 1ns / 1ps
`default_nettype none
package uwxce_pkg;
	localparam int unsigned ChunkBytes = 40;
	localparam int unsigned NumRegs = 7;
	localparam int unsigned IdxW = 3;

	typedef enum logic [3:0] {
		OP_CMOV = 4'd0, OP_LOAD = 4'd1, OP_STORE = 4'd2, OP_ADD = 4'd3,
		OP_MUL = 4'd4, OP_DIV = 4'd5, OP_NAND = 4'd6, OP_HALT = 4'd7,
		OP_MAP = 4'd8, OP_UNMAP = 4'd9, OP_OUT = 4'd10, OP_IN = 4'd11,
		OP_LOADP = 4'd12, OP_ORTHO = 4'd13, OP_BAD14 = 4'd14, OP_BAD15 = 4'd15
	} opcode_t;

	typedef enum logic [2:0] {
		REG_SEG = 3'd0, REG_CNT = 3'd1, REG_MAP = 3'd2, REG_UNMAP = 3'd3,
		REG_OUTR = 3'd4, REG_INR = 3'd5, REG_LDR = 3'd6, REG_NONE = 3'd7
	} reg_sel_t;

	// decoded instruction, passed front to back
	typedef struct packed {
		opcode_t     op;
		logic [2:0]  a;
		logic [2:0]  b;
		logic [2:0]  c;
		logic [2:0]  ra;
		logic [24:0] imm;
		reg_sel_t    rsel;
	} dec_t;
endpackage
`default_nettype wire

>>> hw/rtl/uwxce_if.sv
// Interfaces: valid/ready channels for input words, output bytes and config writes.
`timescale 1ns / 1ps
`default_nettype none
interface uwxce_word_if;
	logic        valid;
	logic        ready;
	logic [31:0] instruction_word;
	modport source (output valid, output instruction_word, input ready);
	modport sink (input valid, input instruction_word, output ready);
endinterface

interface uwxce_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] code_byte;
	logic [5:0] byte_index;
	logic       last_byte;
	modport source (output valid, output code_byte, output byte_index, output last_byte,
		input ready);
	modport sink (input valid, input code_byte, input byte_index, input last_byte,
		output ready);
endinterface

interface uwxce_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [63:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/uwxce_front.sv
// Front end: accepts instruction words, decodes them and queues them (depth 2).
`timescale 1ns / 1ps
`default_nettype none
module uwxce_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	uwxce_word_if.sink          in_ch,
	output uwxce_pkg::dec_t     dec,
	output logic                dec_valid,
	input  wire logic           dec_pop
);
	import uwxce_pkg::*;

	dec_t       q_mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	dec_t       d;
	logic       push;

	always_comb begin
		d.op  = opcode_t'(in_ch.instruction_word[31:28]);
		d.a   = in_ch.instruction_word[8:6];
		d.b   = in_ch.instruction_word[5:3];
		d.c   = in_ch.instruction_word[2:0];
		d.ra  = in_ch.instruction_word[27:25];
		d.imm = in_ch.instruction_word[24:0];
		case (d.op)
			OP_LOAD, OP_STORE: d.rsel = REG_SEG;
			OP_LOADP:          d.rsel = REG_CNT;
			OP_MAP:            d.rsel = REG_MAP;
			OP_UNMAP:          d.rsel = REG_UNMAP;
			OP_OUT:            d.rsel = REG_OUTR;
			OP_IN:             d.rsel = REG_INR;
			default:           d.rsel = REG_NONE;
		endcase
	end

	assign in_ch.ready = (cnt_q != 2'd2);
	assign push = in_ch.valid && in_ch.ready;
	assign dec_valid = (cnt_q != 2'd0);
	assign dec = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) q_mem_q[wr_ptr_q] <= d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (dec_pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, dec_pop};
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 |-> !push) else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		dec_pop |-> cnt_q != 2'd0) else $error("queue underflow");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("queue count out of range");
`endif
endmodule
`default_nettype wire

>>> hw/rtl/uwxce_back.sv
// Back end: walks one decoded instruction's template, one code byte per beat.
`timescale 1ns / 1ps
`default_nettype none
module uwxce_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  uwxce_pkg::dec_t     dec,
	input  wire logic           dec_valid,
	output logic                dec_pop,
	input  wire logic [63:0]    addr,
	output uwxce_pkg::reg_sel_t addr_sel,
	uwxce_byte_if.source        out_ch
);
	import uwxce_pkg::*;

	logic [5:0] pos_q;
	logic [7:0] byte_c;
	logic       adv;
	logic       last;
	logic [2:0] a, b, c;

	assign a = dec.a;
	assign b = dec.b;
	assign c = dec.c;
	// load-program switches to the loader routine address for its second immediate
	assign addr_sel = (dec.op == OP_LOADP && pos_q >= 6'd29) ? REG_LDR : dec.rsel;

	// byte k of the 64-bit address at template offset off
	function automatic logic [7:0] abyte(input logic [63:0] v, input logic [5:0] p,
		input logic [5:0] off);
		logic [5:0] k;
		k = p - off;
		return v[{k[2:0], 3'b000} +: 8];
	endfunction

	// nop3 fill from offset off; k mod 3 by reciprocal multiply
	function automatic logic [7:0] nop3(input logic [5:0] p, input logic [5:0] off);
		logic [5:0]  k;
		logic [11:0] prod;
		logic [5:0]  q3;
		logic [1:0]  m;
		k = p - off;
		prod = {6'd0, k} * 12'd43;
		q3 = {prod[11:7], 1'b0} + {1'b0, prod[11:7]};
		m = 2'(k - q3);
		return (m == 2'd0) ? 8'h0F : (m == 2'd1) ? 8'h1F : 8'h00;
	endfunction

	// routine call template starting at 0
	function automatic logic [7:0] call_b(input logic [5:0] p, input logic [2:0] r,
		input logic [63:0] v);
		logic [7:0] q;
		case (p)
			6'd0: q = 8'h44;
			6'd1: q = 8'h89;
			6'd2: q = {2'b11, r, 3'b111};
			6'd3, 6'd5, 6'd7, 6'd9: q = 8'h41;
			6'd4: q = 8'h50;
			6'd6: q = 8'h51;
			6'd8: q = 8'h52;
			6'd10: q = 8'h53;
			6'd11: q = 8'h48;
			6'd12: q = 8'hB8;
			6'd21: q = 8'hFF;
			6'd22: q = 8'hD0;
			6'd23, 6'd25, 6'd27, 6'd29: q = 8'h41;
			6'd24: q = 8'h5B;
			6'd26: q = 8'h5A;
			6'd28: q = 8'h59;
			6'd30: q = 8'h58;
			default: q = (p >= 6'd13 && p <= 6'd20) ? abyte(v, p, 6'd13) : 8'h00;
		endcase
		return q;
	endfunction

	always_comb begin
		byte_c = 8'h00;
		case (dec.op)
			OP_CMOV: case (pos_q)
				6'd0: byte_c = 8'h41; 6'd1: byte_c = 8'h83;
				6'd2: byte_c = {5'b11111, c}; 6'd3: byte_c = 8'h00;
				6'd4: byte_c = 8'h74; 6'd5: byte_c = 8'h03;
				6'd6: byte_c = 8'h45; 6'd7: byte_c = 8'h89;
				6'd8: byte_c = {2'b11, b, a};
				6'd39: byte_c = 8'h90;
				default: byte_c = nop3(pos_q, 6'd9);
			endcase
			OP_LOAD, OP_STORE: begin
				if (pos_q < 6'd2) byte_c = (pos_q == 6'd0) ? 8'h48 : 8'hB8;
				else if (pos_q < 6'd10) byte_c = abyte(addr, pos_q, 6'd2);
				else case (pos_q)
					6'd10: byte_c = 8'h48; 6'd11: byte_c = 8'h8B; 6'd12: byte_c = 8'h00;
					6'd13: byte_c = 8'h44; 6'd14: byte_c = 8'h89;
					6'd15: byte_c = {2'b11, (dec.op == OP_LOAD) ? b : a, 3'b111};
					6'd16: byte_c = 8'h44; 6'd17: byte_c = 8'h89;
					6'd18: byte_c = {2'b11, (dec.op == OP_LOAD) ? c : b, 3'b110};
					default: if (dec.op == OP_LOAD) case (pos_q)
						6'd19: byte_c = 8'h48; 6'd20: byte_c = 8'h8B;
						6'd21: byte_c = 8'h04; 6'd22: byte_c = 8'hF8;
						6'd23: byte_c = 8'h8B; 6'd24: byte_c = 8'h04; 6'd25: byte_c = 8'hB0;
						6'd26: byte_c = 8'h41; 6'd27: byte_c = 8'h89;
						6'd28: byte_c = {5'b11000, a};
						6'd38, 6'd39: byte_c = 8'h90;
						default: byte_c = nop3(pos_q, 6'd29);
					endcase else case (pos_q)
						6'd19: byte_c = 8'h44; 6'd20: byte_c = 8'h89;
						6'd21: byte_c = {2'b11, c, 3'b010};
						6'd22: byte_c = 8'h48; 6'd23: byte_c = 8'h8B;
						6'd24: byte_c = 8'h04; 6'd25: byte_c = 8'hF8;
						6'd26: byte_c = 8'h89; 6'd27: byte_c = 8'h14; 6'd28: byte_c = 8'hB0;
						6'd38, 6'd39: byte_c = 8'h90;
						default: byte_c = nop3(pos_q, 6'd29);
					endcase
				endcase
			end
			OP_ADD, OP_MUL: case (pos_q)
				6'd0: byte_c = 8'h44; 6'd1: byte_c = 8'h89;
				6'd2: byte_c = {2'b11, b, 3'b000};
				6'd3: byte_c = (dec.op == OP_ADD) ? 8'h44 : 8'h41;
				6'd4: byte_c = (dec.op == OP_ADD) ? 8'h01 : 8'hF7;
				6'd5: byte_c = (dec.op == OP_ADD) ? {2'b11, c, 3'b000} : {5'b11100, c};
				6'd6: byte_c = 8'h41; 6'd7: byte_c = 8'h89;
				6'd8: byte_c = {5'b11000, a};
				6'd39: byte_c = 8'h90;
				default: byte_c = nop3(pos_q, 6'd9);
			endcase
			OP_DIV: case (pos_q)
				6'd0: byte_c = 8'h48; 6'd1: byte_c = 8'h31; 6'd2: byte_c = 8'hD2;
				6'd3: byte_c = 8'h44; 6'd4: byte_c = 8'h89;
				6'd5: byte_c = {2'b11, b, 3'b000};
				6'd6: byte_c = 8'h49; 6'd7: byte_c = 8'hF7;
				6'd8: byte_c = {5'b11110, c};
				6'd9: byte_c = 8'h41; 6'd10: byte_c = 8'h89;
				6'd11: byte_c = {5'b11000, a};
				6'd39: byte_c = 8'h90;
				default: byte_c = nop3(pos_q, 6'd12);
			endcase
			OP_NAND: case (pos_q)
				6'd0: byte_c = 8'h44; 6'd1: byte_c = 8'h89;
				6'd2: byte_c = {2'b11, b, 3'b000};
				6'd3: byte_c = 8'h44; 6'd4: byte_c = 8'h21;
				6'd5: byte_c = {2'b11, c, 3'b000};
				6'd6: byte_c = 8'h40; 6'd7: byte_c = 8'hF7; 6'd8: byte_c = 8'hD0;
				6'd9: byte_c = 8'h41; 6'd10: byte_c = 8'h89;
				6'd11: byte_c = {5'b11000, a};
				6'd39: byte_c = 8'h90;
				default: byte_c = nop3(pos_q, 6'd12);
			endcase
			OP_HALT: case (pos_q)
				6'd0: byte_c = 8'h48; 6'd1: byte_c = 8'h31;
				6'd2: byte_c = 8'hC0; 6'd3: byte_c = 8'hC3;
				default: byte_c = 8'h00;
			endcase
			OP_MAP: begin
				if (pos_q < 6'd31) byte_c = call_b(pos_q, c, addr);
				else case (pos_q)
					6'd31: byte_c = 8'h41; 6'd32: byte_c = 8'h89;
					6'd33: byte_c = {5'b11000, b};
					default: byte_c = nop3(pos_q, 6'd34);
				endcase
			end
			OP_UNMAP, OP_OUT: begin
				if (pos_q < 6'd31) byte_c = call_b(pos_q, c, addr);
				else byte_c = nop3(pos_q, 6'd31);
			end
			OP_IN: begin
				if (pos_q < 6'd2) byte_c = (pos_q == 6'd0) ? 8'h48 : 8'hB8;
				else if (pos_q < 6'd10) byte_c = abyte(addr, pos_q, 6'd2);
				else case (pos_q)
					6'd10: byte_c = 8'hFF; 6'd11: byte_c = 8'hD0;
					6'd12: byte_c = 8'h41; 6'd13: byte_c = 8'h89;
					6'd14: byte_c = {5'b11000, c};
					6'd39: byte_c = 8'h90;
					default: byte_c = nop3(pos_q, 6'd15);
				endcase
			end
			OP_LOADP: begin
				if (pos_q >= 6'd8 && pos_q < 6'd16) byte_c = abyte(addr, pos_q, 6'd8);
				else if (pos_q >= 6'd29 && pos_q < 6'd37) byte_c = abyte(addr, pos_q, 6'd29);
				else case (pos_q)
					6'd0: byte_c = 8'h44; 6'd1: byte_c = 8'h89;
					6'd2: byte_c = {2'b11, b, 3'b111};
					6'd3: byte_c = 8'h44; 6'd4: byte_c = 8'h89;
					6'd5: byte_c = {2'b11, c, 3'b110};
					6'd6: byte_c = 8'h48; 6'd7: byte_c = 8'hB8;
					6'd16: byte_c = 8'h89; 6'd17: byte_c = 8'h30;
					6'd18: byte_c = 8'h85; 6'd19: byte_c = 8'hFF;
					6'd20: byte_c = 8'h75; 6'd21: byte_c = 8'h05;
					6'd22: byte_c = 8'h48; 6'd23: byte_c = 8'h8B;
					6'd24: byte_c = 8'h40; 6'd25: byte_c = 8'h04;
					6'd26: byte_c = 8'hC3;
					6'd27: byte_c = 8'h48; 6'd28: byte_c = 8'hB8;
					6'd37: byte_c = 8'hFF; 6'd38: byte_c = 8'hD0;
					6'd39: byte_c = 8'hC3;
					default: byte_c = 8'h00;
				endcase
			end
			OP_ORTHO: case (pos_q)
				6'd0: byte_c = 8'h41; 6'd1: byte_c = 8'hC7;
				6'd2: byte_c = {5'b11000, dec.ra};
				6'd3: byte_c = dec.imm[7:0];
				6'd4: byte_c = dec.imm[15:8];
				6'd5: byte_c = dec.imm[23:16];
				6'd6: byte_c = {7'd0, dec.imm[24]};
				default: byte_c = nop3(pos_q, 6'd7);
			endcase
			default: byte_c = 8'h00;
		endcase
	end

	// output register; loads when empty or being drained
	assign last = (pos_q == 6'(ChunkBytes - 1));
	assign adv = dec_valid && (!out_ch.valid || out_ch.ready);
	assign dec_pop = adv && last;

	always_ff @(posedge clk) begin
		if (adv) begin
			out_ch.code_byte <= byte_c;
			out_ch.byte_index <= pos_q;
			out_ch.last_byte <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 6'd0;
			out_ch.valid <= 1'b0;
		end else begin
			if (adv) pos_q <= last ? 6'd0 : pos_q + 6'd1;
			if (adv) out_ch.valid <= 1'b1;
			else if (out_ch.ready) out_ch.valid <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q < 6'(ChunkBytes)) else $error("byte position out of range");
	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (out_ch.last_byte == (out_ch.byte_index == 6'(ChunkBytes - 1))))
		else $error("last_byte mismatch");
	a_pos_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(pos_q)) else $error("position moved without advance");
`endif
endmodule
`default_nettype wire

>>> hw/rtl/um_word_to_x86_chunk_emitter_top.sv
// Top level: config registers, decode front end, byte emitting back end.
//   channel  dir  beat
//   in_ch    in   instruction_word
//   out_ch   out  code_byte, byte_index, last_byte
//   cfg_ch   in   index, data
// Each word gives 40 output beats, one per cycle while out_ch is ready; the
// back end's byte counter steps through them in order. A two-entry queue lets words
// be accepted while bytes drain. Reset clears config, queue and counter.
// Config writes are always accepted; indexes above six are ignored.
`timescale 1ns / 1ps
`default_nettype none
module um_word_to_x86_chunk_emitter_top (
	input  wire logic clk,
	input  wire logic arst_n,
	uwxce_word_if.sink   in_ch,
	uwxce_byte_if.source out_ch,
	uwxce_cfg_if.sink    cfg_ch
);
	import uwxce_pkg::*;

	logic [63:0] regs_q [NumRegs];
	dec_t        dec;
	logic        dec_valid, dec_pop;
	reg_sel_t    sel;
	logic [63:0] addr;

	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NumRegs; i++) regs_q[i] <= 64'd0;
		end else if (cfg_ch.valid && cfg_ch.index != 3'(NumRegs)) begin
			regs_q[cfg_ch.index] <= cfg_ch.data;
		end
	end

	assign addr = (sel == REG_NONE) ? 64'd0 : regs_q[sel];

	uwxce_front u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch),
		.dec(dec), .dec_valid(dec_valid), .dec_pop(dec_pop)
	);

	uwxce_back u_back (
		.clk(clk), .arst_n(arst_n), .dec(dec), .dec_valid(dec_valid),
		.dec_pop(dec_pop), .addr(addr), .addr_sel(sel), .out_ch(out_ch)
	);
endmodule
`default_nettype wire
